// ===== rtl/assert_macros.svh =====
// assertion macros used by the rtl file gap_fill_line_interpolator_unit
// no dependencies; the including module provides clk_i and rst_ni
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at every rising edge outside of reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// property checked at every rising edge, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== rtl/gfli_pkg.sv =====
// shared widths, weight codes and gap lookup functions for the line interpolator
// no dependencies
package gfli_pkg;

  localparam int unsigned PIX_W   = 8;
  localparam int unsigned GAP_W   = 3;
  localparam int unsigned MAX_GAP = 4;

  // reciprocal of three, scaled by 2**RECIP3_SH
  localparam int unsigned RECIP3_SH = 11;
  localparam logic [9:0]  RECIP3    = 10'd683;

  // weight of stored pixel : weight of new pixel
  typedef enum logic [2:0] {
    W_31 = 3'd0,
    W_21 = 3'd1,
    W_11 = 3'd2,
    W_12 = 3'd3,
    W_13 = 3'd4
  } weight_e;

  // number of interpolated pairs; out-of-range counts insert nothing
  function automatic logic [GAP_W-1:0] gap_len(logic [GAP_W-1:0] gap);
    logic [GAP_W-1:0] n;
    n = (gap <= GAP_W'(MAX_GAP)) ? gap : '0;
    return n;
  endfunction

  // weight code for the idx-th interpolated pair of a gap
  function automatic weight_e gap_weight(logic [GAP_W-1:0] gap, logic [1:0] idx);
    weight_e w;
    w = W_11;
    case (gap)
      3'd2: w = (idx == 2'd0) ? W_21 : W_12;
      3'd3: begin
        unique case (idx)
          2'd0:    w = W_21;
          2'd1:    w = W_11;
          default: w = W_12;
        endcase
      end
      3'd4: begin
        unique case (idx)
          2'd0: w = W_31;
          2'd1: w = W_21;
          2'd2: w = W_12;
          2'd3: w = W_13;
        endcase
      end
      default: w = W_11;
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/gfli_if.sv =====
// valid/ready channel interfaces for pixel requests and result pairs
// depends on gfli_pkg
interface gfli_in_if import gfli_pkg::*;;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] right_pixel;
  logic [PIX_W-1:0] left_pixel;
  logic [GAP_W-1:0] gap_count;
  logic             line_start;

  modport source (output valid, right_pixel, left_pixel, gap_count, line_start,
                  input ready);
  modport sink   (input valid, right_pixel, left_pixel, gap_count, line_start,
                  output ready);
endinterface

interface gfli_out_if import gfli_pkg::*;;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] out_right;
  logic [PIX_W-1:0] out_left;
  logic             run_last;

  modport source (output valid, out_right, out_left, run_last, input ready);
  modport sink   (input valid, out_right, out_left, run_last, output ready);
endinterface

// ===== rtl/gfli_weigh.sv =====
// weighted mean of a stored and a new pixel with truncation
// depends on gfli_pkg
module gfli_weigh import gfli_pkg::*; (
  input  logic [PIX_W-1:0] a_i,
  input  logic [PIX_W-1:0] b_i,
  input  weight_e          weight_i,
  output logic [PIX_W-1:0] mean_o
);

  logic [PIX_W:0]       sum2;
  logic [PIX_W+1:0]     a2, b2, num3, num4;
  logic [PIX_W+1:0]     a_x, b_x;
  logic [PIX_W+11:0]    prod3;
  logic [PIX_W-1:0]     half, third, quarter;

  always_comb begin
    a_x  = {2'b00, a_i};
    b_x  = {2'b00, b_i};
    a2   = {1'b0, a_i, 1'b0};
    b2   = {1'b0, b_i, 1'b0};
    sum2 = {1'b0, a_i} + {1'b0, b_i};
    num3 = (weight_i == W_21) ? (a2 + b_x) : (a_x + b2);
    num4 = (weight_i == W_31) ? (a2 + a_x + b_x) : (a_x + b2 + b_x);
    // x/3 as x*683 >> 11, exact for x below 2048
    prod3   = (PIX_W + 12)'(num3) * (PIX_W + 12)'(RECIP3);
    half    = sum2[PIX_W:1];
    third   = prod3[RECIP3_SH +: PIX_W];
    quarter = num4[PIX_W+1:2];
    unique case (weight_i)
      W_11:        mean_o = half;
      W_21, W_12:  mean_o = third;
      W_31, W_13:  mean_o = quarter;
      default:     mean_o = half;
    endcase
  end

endmodule

// ===== rtl/gap_fill_line_interpolator_unit.sv =====
// one request in: a work register walks its interpolated pairs, then the new pair.
// throughput: one result per cycle while out_o.ready does not stall the output; a request
// yields gap_count + 1 results (one on a line start or a gap count above four), all
// passed through the single output register, and the next request is accepted as the
// last result of the current one is emitted.
// reset clears the valid flags and the stored pixel pair to zero.
module gap_fill_line_interpolator_unit import gfli_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  gfli_in_if.sink     in_i,
  gfli_out_if.source  out_o
);

`include "assert_macros.svh"

  logic             work_v_q, work_v_d;
  logic [PIX_W-1:0] ar_q, al_q, br_q, bl_q;
  logic [PIX_W-1:0] prev_r_q, prev_l_q;
  logic [GAP_W-1:0] gap_q, n_q, idx_q, idx_d;
  logic             out_v_q, out_v_d;
  logic [PIX_W-1:0] out_r_q, out_l_q;
  logic             out_last_q;

  logic             in_fire, emit, work_last;
  weight_e          weight;
  logic [PIX_W-1:0] mean_r, mean_l;

  assign in_fire   = in_i.valid && in_i.ready;
  assign work_last = (idx_q == n_q);
  assign emit      = work_v_q && (!out_v_q || out_o.ready);
  assign in_i.ready = !work_v_q || (emit && work_last);
  assign weight    = gap_weight(gap_q, idx_q[1:0]);

  gfli_weigh u_weigh_r (.a_i(ar_q), .b_i(br_q), .weight_i(weight), .mean_o(mean_r));
  gfli_weigh u_weigh_l (.a_i(al_q), .b_i(bl_q), .weight_i(weight), .mean_o(mean_l));

  always_comb begin
    work_v_d = work_v_q;
    idx_d    = idx_q;
    if (in_fire) begin
      work_v_d = 1'b1;
      idx_d    = '0;
    end else if (emit) begin
      work_v_d = !work_last;
      idx_d    = idx_q + GAP_W'(1);
    end
    out_v_d = out_v_q;
    if (emit) begin
      out_v_d = 1'b1;
    end else if (out_o.ready) begin
      out_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      work_v_q <= 1'b0;
      idx_q    <= '0;
      out_v_q  <= 1'b0;
      prev_r_q <= '0;
      prev_l_q <= '0;
    end else begin
      work_v_q <= work_v_d;
      idx_q    <= idx_d;
      out_v_q  <= out_v_d;
      if (in_fire) begin
        prev_r_q <= in_i.right_pixel;
        prev_l_q <= in_i.left_pixel;
      end
    end
  end

  // request payload, span taken from the stored pair at accept time
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      ar_q  <= prev_r_q;
      al_q  <= prev_l_q;
      br_q  <= in_i.right_pixel;
      bl_q  <= in_i.left_pixel;
      gap_q <= in_i.gap_count;
      n_q   <= in_i.line_start ? '0 : gap_len(in_i.gap_count);
    end
    if (emit) begin
      out_r_q    <= work_last ? br_q : mean_r;
      out_l_q    <= work_last ? bl_q : mean_l;
      out_last_q <= work_last;
    end
  end

  assign out_o.valid     = out_v_q;
  assign out_o.out_right = out_r_q;
  assign out_o.out_left  = out_l_q;
  assign out_o.run_last  = out_last_q;

  `ASSERT_CLK(a_accept_free, in_fire |-> (!work_v_q || (emit && work_last)), "busy")
  `ASSERT_CLK(a_idx_range, work_v_q |-> (idx_q <= n_q && n_q <= GAP_W'(MAX_GAP)), "index")
  `ASSERT_CLK(a_mid_keeps_work, (emit && !work_last) |=> work_v_q, "work dropped mid-run")
  `ASSERT_CLK(a_start_no_gap, (in_fire && in_i.line_start) |=> (n_q == '0), "gap on start")

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// testbench for gap_fill_line_interpolator_unit: a directed table, then random scan lines
// depends on gfli_pkg, the gfli_in_if / gfli_out_if channels and the unit itself
module tb;
  import gfli_pkg::*;

  localparam int unsigned NUM_RANDOM  = 450;
  localparam int unsigned NUM_ROWS    = 19;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned MAX_REPORTS = 10;

  typedef struct packed {
    logic [PIX_W-1:0] right;
    logic [PIX_W-1:0] left;
    logic [GAP_W-1:0] gap;
    logic             start;
  } pix_req_t;

  typedef struct packed {
    logic [PIX_W-1:0] right;
    logic [PIX_W-1:0] left;
    logic             last;
  } pair_t;

  // typed rows expect exactly one pair, the one given in exp_right / exp_left
  typedef struct packed {
    logic [PIX_W-1:0] right;
    logic [PIX_W-1:0] left;
    logic [GAP_W-1:0] gap;
    logic             start;
    logic             typed;
    logic [PIX_W-1:0] exp_right;
    logic [PIX_W-1:0] exp_left;
  } table_row_t;

  typedef enum logic [1:0] {
    SINK_OPEN,
    SINK_COIN,
    SINK_SPARSE,
    SINK_SQUARE
  } sink_mode_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  gfli_in_if  in_ch ();
  gfli_out_if out_ch ();

  gap_fill_line_interpolator_unit uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  always #6 clk_i = ~clk_i;

  pair_t            pending_pairs[$];
  logic [PIX_W-1:0] held_right = '0;
  logic [PIX_W-1:0] held_left  = '0;
  int unsigned      mismatches = 0;
  int unsigned      cycle_count = 0;
  int unsigned      burst_left = 0;
  sink_mode_e       sink_mode = SINK_OPEN;
  int unsigned      mode_left = 0;
  logic [7:0]       sink_phase = '0;

  table_row_t dir_rows [NUM_ROWS] = '{
    // interpolation from the zero pair left by reset
    '{8'hFF, 8'hFF, 3'd4, 1'b0, 1'b0, 8'h00, 8'h00},
    '{8'h12, 8'h34, 3'd0, 1'b0, 1'b1, 8'h12, 8'h34},
    // gap count ignored on a line start
    '{8'h00, 8'hFF, 3'd3, 1'b1, 1'b1, 8'h00, 8'hFF},
    '{8'hFF, 8'h00, 3'd4, 1'b0, 1'b0, 8'h00, 8'h00},
    '{8'hFF, 8'h00, 3'd1, 1'b0, 1'b0, 8'h00, 8'h00},
    '{8'h00, 8'hFF, 3'd2, 1'b0, 1'b0, 8'h00, 8'h00},
    '{8'h00, 8'h00, 3'd3, 1'b0, 1'b0, 8'h00, 8'h00},
    '{8'hFF, 8'hFF, 3'd4, 1'b0, 1'b0, 8'h00, 8'h00},
    // gap counts above four insert nothing
    '{8'hAA, 8'h55, 3'd5, 1'b0, 1'b1, 8'hAA, 8'h55},
    '{8'h55, 8'hAA, 3'd6, 1'b0, 1'b1, 8'h55, 8'hAA},
    '{8'h01, 8'hFE, 3'd7, 1'b0, 1'b1, 8'h01, 8'hFE},
    '{8'h80, 8'h7F, 3'd4, 1'b0, 1'b0, 8'h00, 8'h00},
    '{8'hFF, 8'h00, 3'd7, 1'b1, 1'b1, 8'hFF, 8'h00},
    '{8'h00, 8'hFF, 3'd1, 1'b0, 1'b0, 8'h00, 8'h00},
    '{8'h01, 8'h02, 3'd2, 1'b0, 1'b0, 8'h00, 8'h00},
    '{8'hFE, 8'hFD, 3'd3, 1'b0, 1'b0, 8'h00, 8'h00},
    '{8'h00, 8'h00, 3'd0, 1'b1, 1'b1, 8'h00, 8'h00},
    '{8'hFF, 8'hFF, 3'd0, 1'b1, 1'b1, 8'hFF, 8'hFF},
    '{8'hFE, 8'h01, 3'd4, 1'b0, 1'b0, 8'h00, 8'h00}
  };

  function automatic logic [PIX_W-1:0] blend(logic [PIX_W-1:0] a, logic [PIX_W-1:0] b,
                                             weight_e w);
    int unsigned wa, wb;
    case (w)
      W_31:    begin wa = 3; wb = 1; end
      W_21:    begin wa = 2; wb = 1; end
      W_11:    begin wa = 1; wb = 1; end
      W_12:    begin wa = 1; wb = 2; end
      default: begin wa = 1; wb = 3; end
    endcase
    return PIX_W'((wa * a + wb * b) / (wa + wb));
  endfunction

  // queues the pairs a request produces (when asked) and moves the stored pair on
  function automatic void advance_line(pix_req_t rq, logic predict);
    weight_e     steps [4];
    int unsigned n;
    int unsigned i;
    n = 0;
    steps = '{W_11, W_11, W_11, W_11};
    if (!rq.start) begin
      case (rq.gap)
        3'd1: begin steps[0] = W_11; n = 1; end
        3'd2: begin steps[0] = W_21; steps[1] = W_12; n = 2; end
        3'd3: begin steps[0] = W_21; steps[1] = W_11; steps[2] = W_12; n = 3; end
        3'd4: begin
          steps = '{W_31, W_21, W_12, W_13};
          n = 4;
        end
        default: n = 0;
      endcase
    end
    if (predict) begin
      for (i = 0; i < n; i++) begin
        pending_pairs.push_back(pair_t'{blend(held_right, rq.right, steps[i]),
                                        blend(held_left, rq.left, steps[i]), 1'b0});
      end
      pending_pairs.push_back(pair_t'{rq.right, rq.left, 1'b1});
    end
    held_right = rq.right;
    held_left  = rq.left;
  endfunction

  function automatic logic [PIX_W-1:0] rand_pixel();
    logic [PIX_W-1:0] p;
    case ($urandom_range(0, 7))
      0:       p = '0;
      1:       p = '1;
      default: p = PIX_W'($urandom_range(0, 255));
    endcase
    return p;
  endfunction

  // called at a falling edge; returns at the falling edge where the next request may go out
  task automatic send_request(input pix_req_t rq, input logic typed,
                              input logic [PIX_W-1:0] er, input logic [PIX_W-1:0] el);
    in_ch.valid       <= 1'b1;
    in_ch.right_pixel <= rq.right;
    in_ch.left_pixel  <= rq.left;
    in_ch.gap_count   <= rq.gap;
    in_ch.line_start  <= rq.start;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    if (typed) pending_pairs.push_back(pair_t'{er, el, 1'b1});
    advance_line(rq, !typed);
    @(negedge clk_i);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 8);
    end
  endtask

  initial begin : stimulus
    pix_req_t    rq;
    table_row_t  row;
    int unsigned sent;
    int unsigned line_len;
    in_ch.valid       = 1'b0;
    in_ch.right_pixel = '0;
    in_ch.left_pixel  = '0;
    in_ch.gap_count   = '0;
    in_ch.line_start  = 1'b0;
    burst_left = $urandom_range(1, 16);
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int r = 0; r < NUM_ROWS; r++) begin
      row = dir_rows[r];
      rq  = '{row.right, row.left, row.gap, row.start};
      send_request(rq, row.typed, row.exp_right, row.exp_left);
    end

    // mostly well-formed lines with random content, some stray starts and bad gaps
    sent = 0;
    while (sent < NUM_RANDOM) begin
      if ($urandom_range(0, 7) != 0) begin
        rq = '{rand_pixel(), rand_pixel(), GAP_W'($urandom_range(0, 7)), 1'b1};
        send_request(rq, 1'b0, '0, '0);
        sent++;
      end
      line_len = $urandom_range(1, 12);
      repeat (line_len) begin
        rq.right = rand_pixel();
        rq.left  = rand_pixel();
        rq.gap   = ($urandom_range(0, 9) == 0) ? GAP_W'($urandom_range(5, 7))
                                                : GAP_W'($urandom_range(0, 4));
        rq.start = ($urandom_range(0, 19) == 0);
        send_request(rq, 1'b0, '0, '0);
        sent++;
      end
    end
    in_ch.valid <= 1'b0;

    while (pending_pairs.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  always @(negedge clk_i) begin : sink_pattern
    if (mode_left == 0) begin
      sink_mode = sink_mode_e'($urandom_range(0, 3));
      mode_left = $urandom_range(20, 80);
    end
    mode_left--;
    sink_phase++;
    case (sink_mode)
      SINK_OPEN:   out_ch.ready <= 1'b1;
      SINK_COIN:   out_ch.ready <= 1'($urandom_range(0, 1));
      SINK_SPARSE: out_ch.ready <= (sink_phase[1:0] == 2'd0);
      default:     out_ch.ready <= ~sink_phase[2];
    endcase
  end

  always @(posedge clk_i) begin : result_check
    pair_t got;
    pair_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.out_right, out_ch.out_left, out_ch.run_last};
      if (pending_pairs.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected pair: r=%0d l=%0d last=%0d", got.right, got.left, got.last);
      end else begin
        want = pending_pairs.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("mismatch: expected r=%0d l=%0d last=%0d, got r=%0d l=%0d last=%0d",
                     want.right, want.left, want.last, got.right, got.left, got.last);
        end
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

endmodule
